// ===== rtl/gbc_pkg.sv =====
// Shared types, codes and column search helpers for the glyph bitmap crop block.
// No dependencies.
package gbc_pkg;

    localparam int ROW_BITS = 64;
    localparam int POS_W    = 6;
    localparam int OFF_W    = 12;

    localparam logic KIND_META = 1'b0;
    localparam logic KIND_ROW  = 1'b1;

    typedef struct packed {
        logic             has_ink;
        logic [POS_W-1:0] min_col;
        logic [POS_W-1:0] max_col;
        logic [POS_W-1:0] min_row;
        logic [POS_W-1:0] max_row;
        logic [POS_W-1:0] rows_seen;
    } ink_stat_t;

    typedef struct packed {
        logic [6:0]       wd;
        logic [5:0]       ht;
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic [OFF_W-1:0] x_off;
        logic [OFF_W-1:0] y_off;
    } glyph_box_t;

    typedef struct packed {
        logic [OFF_W-1:0] span;
        logic [OFF_W-1:0] ascent;
        logic [OFF_W-1:0] descent;
        logic [OFF_W-1:0] min_left;
        logic             mono;
    } font_stat_t;

    function automatic logic [POS_W-1:0] first_col(input logic [ROW_BITS-1:0] v);
        logic [7:0]       any;
        logic [2:0]       sub [8];
        logic [POS_W-1:0] res;
        res = '0;
        for (int b = 0; b < 8; b++)
        begin
            any[b] = |v[63-8*b -: 8];
            sub[b] = '0;
            for (int k = 7; k >= 0; k--)
            begin
                if (v[63-8*b-k])
                    sub[b] = 3'(k);
            end
        end
        for (int b = 7; b >= 0; b--)
        begin
            if (any[b])
                res = {3'(b), sub[b]};
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] last_col(input logic [ROW_BITS-1:0] v);
        logic [7:0]       any;
        logic [2:0]       sub [8];
        logic [POS_W-1:0] res;
        res = '0;
        for (int b = 0; b < 8; b++)
        begin
            any[b] = |v[63-8*b -: 8];
            sub[b] = '0;
            for (int k = 0; k < 8; k++)
            begin
                if (v[63-8*b-k])
                    sub[b] = 3'(k);
            end
        end
        for (int b = 0; b < 8; b++)
        begin
            if (any[b])
                res = {3'(b), sub[b]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/gbc_ink_track.sv =====
// Row masking, store write port and running ink box of the current glyph.
// Depends on gbc_pkg.
module gbc_ink_track
    import gbc_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 63
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        acc,
    input  logic                        clr,
    input  logic [ROW_BITS-1:0]         row_bits,
    input  logic [6:0]                  row_width,
    output ink_stat_t                   stat,
    output logic                        wr_en,
    output logic [$clog2(MAX_ROWS)-1:0] wr_addr,
    output logic [MAX_COLS-1:0]         wr_data
);

    localparam int AW = $clog2(MAX_ROWS);

    ink_stat_t           stat_reg;
    ink_stat_t           stat_next;
    logic [6:0]          w_sat;
    logic [ROW_BITS-1:0] masked;
    logic                room;
    logic [POS_W-1:0]    f_col;
    logic [POS_W-1:0]    l_col;

    always_comb
    begin
        w_sat  = (row_width > 7'(MAX_COLS)) ? 7'(MAX_COLS) : row_width;
        masked = row_bits & ~({ROW_BITS{1'b1}} >> w_sat);
        room   = stat_reg.rows_seen < POS_W'(MAX_ROWS);
        f_col  = first_col(masked);
        l_col  = last_col(masked);
    end

    always_comb
    begin
        stat_next = stat_reg;
        if (clr)
        begin
            stat_next = '0;
        end
        else if (acc && room)
        begin
            if (|masked)
            begin
                if (!stat_reg.has_ink)
                begin
                    stat_next.min_col = f_col;
                    stat_next.max_col = l_col;
                    stat_next.min_row = stat_reg.rows_seen;
                end
                else
                begin
                    if (f_col < stat_reg.min_col)
                        stat_next.min_col = f_col;
                    if (l_col > stat_reg.max_col)
                        stat_next.max_col = l_col;
                end
                stat_next.has_ink = 1'b1;
                stat_next.max_row = stat_reg.rows_seen;
            end
            stat_next.rows_seen = stat_reg.rows_seen + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stat_reg <= '0;
        else
            stat_reg <= stat_next;
    end

    assign stat    = stat_reg;
    assign wr_en   = acc && room;
    assign wr_addr = stat_reg.rows_seen[AW-1:0];
    assign wr_data = masked[ROW_BITS-1 -: MAX_COLS];

endmodule

// ===== rtl/gbc_row_store.sv =====
// Row memory of the current glyph with registered read and crop shifter.
// Depends on gbc_pkg.
module gbc_row_store
    import gbc_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 63
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_ROWS)-1:0] wr_addr,
    input  logic [MAX_COLS-1:0]         wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_ROWS)-1:0] rd_addr,
    input  logic [POS_W-1:0]            sx,
    input  logic [6:0]                  wd,
    output logic [ROW_BITS-1:0]         cropped
);

    localparam int PAD = ROW_BITS - MAX_COLS;

    logic [MAX_COLS-1:0] row_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic [ROW_BITS-1:0] aligned;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= row_mem[rd_addr];
    end

    always_comb
    begin
        aligned = ROW_BITS'(rd_data_reg) << PAD;
        cropped = (aligned << sx) & ~({ROW_BITS{1'b1}} >> wd);
    end

endmodule

// ===== rtl/gbc_font_stats.sv =====
// Font-wide ascent, descent, bearings and monowidth flag, updated once per glyph.
// Depends on gbc_pkg.
module gbc_font_stats
    import gbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       upd,
    input  logic       span_upd,
    input  glyph_box_t box,
    output font_stat_t stats
);

    logic [OFF_W-1:0] ascent_reg;
    logic [OFF_W-1:0] descent_reg;
    logic [OFF_W-1:0] right_reg;
    logic [OFF_W-1:0] left_min_reg;
    logic [OFF_W-1:0] span_reg;
    logic [6:0]       prev_w_reg;
    logic             mono_reg;
    logic             first_reg;

    logic signed [OFF_W:0] asc_c;
    logic signed [OFF_W:0] desc_c;
    logic signed [OFF_W:0] right_c;
    logic signed [OFF_W:0] x_ext;
    logic signed [OFF_W:0] diff;

    always_comb
    begin
        asc_c   = {7'b0, box.ht} + {box.y_off[OFF_W-1], box.y_off};
        desc_c  = {(OFF_W+1){1'b0}} - {box.y_off[OFF_W-1], box.y_off};
        right_c = {6'b0, box.wd} + {box.x_off[OFF_W-1], box.x_off};
        x_ext   = {box.x_off[OFF_W-1], box.x_off};
        diff    = {right_reg[OFF_W-1], right_reg} - {left_min_reg[OFF_W-1], left_min_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascent_reg   <= '0;
            descent_reg  <= '0;
            right_reg    <= '0;
            left_min_reg <= OFF_W'(2047);
            span_reg     <= '0;
            prev_w_reg   <= '0;
            mono_reg     <= 1'b1;
            first_reg    <= 1'b1;
        end
        else
        begin
            if (upd)
            begin
                if (asc_c > $signed({ascent_reg[OFF_W-1], ascent_reg}))
                    ascent_reg <= asc_c[OFF_W-1:0];
                if (desc_c > $signed({descent_reg[OFF_W-1], descent_reg}))
                    descent_reg <= desc_c[OFF_W-1:0];
                if (right_c > $signed({right_reg[OFF_W-1], right_reg}))
                    right_reg <= right_c[OFF_W-1:0];
                if (x_ext < $signed({left_min_reg[OFF_W-1], left_min_reg}))
                    left_min_reg <= box.x_off;
                if (!first_reg && (box.wd != prev_w_reg))
                    mono_reg <= 1'b0;
                prev_w_reg <= box.wd;
                first_reg  <= 1'b0;
            end
            if (span_upd)
                span_reg <= diff[OFF_W] ? '0 : diff[OFF_W-1:0];
        end
    end

    assign stats = '{span:     span_reg,
                     ascent:   ascent_reg,
                     descent:  descent_reg,
                     min_left: left_min_reg,
                     mono:     mono_reg};

endmodule

// ===== rtl/glyph_bitmap_crop.sv =====
// Glyph bitmap crop: one input beat per glyph row, MSB first (bit 63 is column 0).
// Rows of a glyph are taken at one per cycle and written to the row memory while
// the ink box is tracked. The beat with last_row set closes the glyph; the input
// then stalls until the glyph's results are all handed to the output register.
// Result burst: one metrics beat (kind 0), then one beat per ink-box row
// (kind 1) with the row shifted left to the first ink column. last marks the
// final beat. An empty glyph gives only the metrics beat.
// After the last row is taken the metrics beat passes the box, font update,
// font span and load steps; the box step waits until the output register is
// empty. Rows then follow at one per cycle while the receiver does not stall,
// paced by the single read port of the row memory and its registered read. A
// stall on the output holds the current beat; reads pause so that no row is
// lost. The next glyph's rows are taken while the final beat of the previous
// glyph still waits in the output register.
// Reset clears the glyph state and the font statistics (left bearing minimum
// to 2047, monowidth flag to one). The row memory is not cleared; only rows
// written for the current glyph are read.
// Depends on gbc_pkg, gbc_ink_track, gbc_row_store and gbc_font_stats.
module glyph_bitmap_crop
    import gbc_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ROW_BITS-1:0] row_bits,
    input  logic [6:0]          row_width,
    input  logic signed [10:0]  glyph_left,
    input  logic signed [10:0]  glyph_top,
    input  logic                last_row,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [6:0]          box_width,
    output logic [5:0]          box_height,
    output logic signed [11:0]  box_x_offset,
    output logic signed [11:0]  box_y_offset,
    output logic [ROW_BITS-1:0] cropped_row,
    output logic [11:0]         font_box_width,
    output logic [11:0]         font_max_ascent,
    output logic [11:0]         font_max_descent,
    output logic signed [11:0]  font_min_left,
    output logic                all_same_width,
    output logic                last
);

    localparam int AW = $clog2(MAX_ROWS);

    typedef enum logic [4:0] {
        S_IN   = 5'b00001,
        S_BOX  = 5'b00010,
        S_FONT = 5'b00100,
        S_SPAN = 5'b01000,
        S_ROWS = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    ink_stat_t           stat;
    glyph_box_t          box_reg;
    glyph_box_t          box_next;
    font_stat_t          stats;
    logic [10:0]         left_reg;
    logic [10:0]         top_reg;
    logic [POS_W-1:0]    rd_cnt_reg;
    logic [POS_W-1:0]    rd_cnt_next;
    logic [POS_W-1:0]    em_cnt_reg;
    logic [POS_W-1:0]    em_cnt_next;
    logic                head_sent_reg;
    logic                head_sent_next;
    logic                pend_reg;
    logic                pend_next;
    logic                out_valid_reg;
    logic                kind_reg;
    logic                last_reg;
    logic [ROW_BITS-1:0] cropped_reg;

    logic                in_acc;
    logic                clr;
    logic                font_upd;
    logic                span_upd;
    logic                out_free;
    logic                consume;
    logic                rd_en;
    logic [POS_W-1:0]    rd_pos;
    logic                load;
    logic                load_kind;
    logic                load_last;
    logic [ROW_BITS-1:0] load_row;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic [ROW_BITS-1:0] cropped;
    logic [POS_W-1:0]    sx_c;
    logic [POS_W-1:0]    sy_c;

    assign in_stall = (state_reg != S_IN);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    gbc_ink_track #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ink (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (in_acc),
        .clr       (clr),
        .row_bits  (row_bits),
        .row_width (row_width),
        .stat      (stat),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    gbc_row_store #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_pos[AW-1:0]),
        .sx      (box_reg.sx),
        .wd      (box_reg.wd),
        .cropped (cropped)
    );

    gbc_font_stats u_font (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (font_upd),
        .span_upd (span_upd),
        .box      (box_reg),
        .stats    (stats)
    );

    always_comb
    begin
        sx_c           = stat.has_ink ? stat.min_col : '0;
        sy_c           = stat.has_ink ? stat.min_row : '0;
        box_next.sx    = sx_c;
        box_next.sy    = sy_c;
        box_next.wd    = stat.has_ink ? ({1'b0, stat.max_col} - {1'b0, stat.min_col} + 7'd1)
                                      : 7'd0;
        box_next.ht    = stat.has_ink ? (stat.max_row - stat.min_row + 6'd1) : 6'd0;
        box_next.x_off = {6'b0, sx_c} + {left_reg[10], left_reg};
        box_next.y_off = {6'b0, sy_c} + {top_reg[10], top_reg} - {6'b0, stat.rows_seen};
    end

    always_comb
    begin
        consume   = (state_reg == S_ROWS) && pend_reg && head_sent_reg && out_free;
        rd_en     = (state_reg == S_ROWS) && (rd_cnt_reg < box_reg.ht) && (!pend_reg || consume);
        rd_pos    = box_reg.sy + rd_cnt_reg;
        load      = 1'b0;
        load_kind = KIND_META;
        load_last = 1'b0;
        load_row  = '0;
        if (state_reg == S_ROWS)
        begin
            if (!head_sent_reg && out_free)
            begin
                load      = 1'b1;
                load_last = (box_reg.ht == 6'd0);
            end
            else if (consume)
            begin
                load      = 1'b1;
                load_kind = KIND_ROW;
                load_row  = cropped;
                load_last = ((em_cnt_reg + 6'd1) == box_reg.ht);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr            = 1'b0;
        font_upd       = 1'b0;
        span_upd       = 1'b0;
        rd_cnt_next    = rd_cnt_reg;
        em_cnt_next    = em_cnt_reg;
        head_sent_next = head_sent_reg;
        pend_next      = rd_en ? 1'b1 : (consume ? 1'b0 : pend_reg);
        case (state_reg)
            S_IN:
            begin
                if (in_acc && last_row)
                    state_next = S_BOX;
            end
            S_BOX:
            begin
                if (!out_valid_reg)
                begin
                    clr            = 1'b1;
                    rd_cnt_next    = '0;
                    em_cnt_next    = '0;
                    head_sent_next = 1'b0;
                    state_next     = S_FONT;
                end
            end
            S_FONT:
            begin
                font_upd   = 1'b1;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                span_upd   = 1'b1;
                state_next = S_ROWS;
            end
            S_ROWS:
            begin
                if (rd_en)
                    rd_cnt_next = rd_cnt_reg + 6'd1;
                if (consume)
                    em_cnt_next = em_cnt_reg + 6'd1;
                if (load && (load_kind == KIND_META))
                    head_sent_next = 1'b1;
                if (load && load_last)
                    state_next = S_IN;
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            rd_cnt_reg    <= '0;
            em_cnt_reg    <= '0;
            head_sent_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            em_cnt_reg    <= em_cnt_next;
            head_sent_reg <= head_sent_next;
            pend_reg      <= pend_next;
            out_valid_reg <= load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && last_row)
        begin
            left_reg <= glyph_left;
            top_reg  <= glyph_top;
        end
        if ((state_reg == S_BOX) && !out_valid_reg)
            box_reg <= box_next;
        if (load)
        begin
            kind_reg    <= load_kind;
            last_reg    <= load_last;
            cropped_reg <= load_row;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign last             = last_reg;
    assign cropped_row      = cropped_reg;
    assign box_width        = box_reg.wd;
    assign box_height       = box_reg.ht;
    assign box_x_offset     = box_reg.x_off;
    assign box_y_offset     = box_reg.y_off;
    assign font_box_width   = stats.span;
    assign font_max_ascent  = stats.ascent;
    assign font_max_descent = stats.descent;
    assign font_min_left    = stats.min_left;
    assign all_same_width   = stats.mono;

    a_load_only_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ROWS))
        else $error("output beat loaded outside a result burst");

    a_reads_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWS) |-> (rd_cnt_reg <= box_reg.ht) && (em_cnt_reg <= rd_cnt_reg))
        else $error("row read or emit count ran past the ink box");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_last) |=> (state_reg == S_IN))
        else $error("burst did not end after its last beat");

    a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IN) |-> !pend_reg)
        else $error("row read left pending at end of burst");

    a_box_stable_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(box_reg) && $stable(stats))
        else $error("box or font fields changed under a held beat");

endmodule

// ===== tb/sv/glyph_bitmap_crop_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for glyph_bitmap_crop: sends glyph rows and checks the
// metrics and cropped row beats against an in-bench prediction. Depends on gbc_pkg.
module glyph_bitmap_crop_test
    import gbc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int STORE_ROWS  = 63;
    localparam int STORE_COLS  = 64;
    localparam int NO_INK      = 127;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [6:0]  box_w;
        logic [5:0]  box_h;
        logic [11:0] x_off;
        logic [11:0] y_off;
        logic [63:0] bits;
        logic [11:0] span;
        logic [11:0] ascent;
        logic [11:0] descent;
        logic [11:0] min_left;
        logic        mono;
        logic        last;
    } crop_beat_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [63:0]         row_bits     = '0;
    logic [6:0]          row_width    = 7'd1;
    logic signed [10:0]  glyph_left   = '0;
    logic signed [10:0]  glyph_top    = '0;
    logic                last_row     = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                kind;
    logic [6:0]          box_width;
    logic [5:0]          box_height;
    logic signed [11:0]  box_x_offset;
    logic signed [11:0]  box_y_offset;
    logic [63:0]         cropped_row;
    logic [11:0]         font_box_width;
    logic [11:0]         font_max_ascent;
    logic [11:0]         font_max_descent;
    logic signed [11:0]  font_min_left;
    logic                all_same_width;
    logic                last;

    crop_beat_t  expected_beats[$];
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    int          stall_hold   = 0;
    bit          idle_on      = 1'b1;

    // glyph and font state of the prediction
    logic [63:0] glyph_rows [STORE_ROWS];
    int          rows_taken   = 0;
    int          ink_col_lo   = NO_INK;
    int          ink_col_hi   = 0;
    int          ink_row_lo   = STORE_ROWS;
    int          ink_row_hi   = 0;
    int          asc_peak     = 0;
    int          desc_peak    = 0;
    int          right_peak   = 0;
    int          left_floor   = 2047;
    int          prev_box_w   = 0;
    bit          mono_now     = 1'b1;
    bit          no_glyph_yet = 1'b1;

    glyph_bitmap_crop i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .row_bits         (row_bits),
        .row_width        (row_width),
        .glyph_left       (glyph_left),
        .glyph_top        (glyph_top),
        .last_row         (last_row),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .box_width        (box_width),
        .box_height       (box_height),
        .box_x_offset     (box_x_offset),
        .box_y_offset     (box_y_offset),
        .cropped_row      (cropped_row),
        .font_box_width   (font_box_width),
        .font_max_ascent  (font_max_ascent),
        .font_max_descent (font_max_descent),
        .font_min_left    (font_min_left),
        .all_same_width   (all_same_width),
        .last             (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] col_mask(input int w);
        return ~(ONES64 >> w);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [6:0] pick_width();
        if ($urandom_range(0, 9) != 0)
            return 7'($urandom_range(1, STORE_COLS));
        else if ($urandom_range(0, 1) == 0)
            return 7'd0;
        return 7'($urandom_range(STORE_COLS + 1, 127));
    endfunction

    function automatic logic [63:0] rand_row();
        logic [63:0] r;
        int          a;
        int          b;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: r = '0;
            1: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            2: r = 64'h1 << $urandom_range(0, 63);
            3:
            begin
                a = $urandom_range(0, 63);
                b = $urandom_range(a, 63);
                r = (ONES64 >> a) & ~(ONES64 >> (b + 1));
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic predict_row(input logic [63:0] bits, input logic [6:0] width,
                               input logic signed [10:0] left,
                               input logic signed [10:0] top, input logic fin);
        int          w;
        int          f;
        int          l;
        int          sx;
        int          sy;
        int          wd;
        int          ht;
        int          xo;
        int          yo;
        int          fbw;
        logic [63:0] row;
        crop_beat_t  b;
        w   = (width > STORE_COLS) ? STORE_COLS : width;
        row = bits & col_mask(w);
        if (rows_taken < STORE_ROWS)
        begin
            glyph_rows[rows_taken] = row;
            if (row != '0)
            begin
                f = 0;
                while (!row[63 - f])
                    f++;
                l = 63;
                while (!row[63 - l])
                    l--;
                if (f < ink_col_lo)
                    ink_col_lo = f;
                if (l > ink_col_hi)
                    ink_col_hi = l;
                if (rows_taken < ink_row_lo)
                    ink_row_lo = rows_taken;
                if (rows_taken > ink_row_hi)
                    ink_row_hi = rows_taken;
            end
            rows_taken++;
        end
        if (!fin)
            return;

        if (ink_col_lo == NO_INK)
        begin
            sx = 0;
            sy = 0;
            wd = 0;
            ht = 0;
        end
        else
        begin
            sx = ink_col_lo;
            sy = ink_row_lo;
            wd = ink_col_hi + 1 - sx;
            ht = ink_row_hi + 1 - sy;
        end
        xo = sx + int'(left);
        yo = sy + int'(top) - rows_taken;

        if (!no_glyph_yet && wd != prev_box_w)
            mono_now = 1'b0;
        prev_box_w   = wd;
        no_glyph_yet = 1'b0;

        if (ht + yo > asc_peak)
            asc_peak = ht + yo;
        if (-yo > desc_peak)
            desc_peak = -yo;
        if (wd + xo > right_peak)
            right_peak = wd + xo;
        if (xo < left_floor)
            left_floor = xo;
        fbw = right_peak - left_floor;
        if (fbw < 0)
            fbw = 0;
        if (fbw > 4095)
            fbw = 4095;

        for (int y = 0; y <= ht; y++)
        begin
            b.kind     = (y == 0) ? KIND_META : KIND_ROW;
            b.box_w    = 7'(wd);
            b.box_h    = 6'(ht);
            b.x_off    = 12'(xo);
            b.y_off    = 12'(yo);
            b.bits     = (y == 0) ? '0 : (glyph_rows[sy + y - 1] << sx) & col_mask(wd);
            b.span     = 12'(fbw);
            b.ascent   = 12'(asc_peak);
            b.descent  = 12'(desc_peak);
            b.min_left = 12'(left_floor);
            b.mono     = mono_now;
            b.last     = (y == ht);
            expected_beats.push_back(b);
        end

        rows_taken = 0;
        ink_col_lo = NO_INK;
        ink_col_hi = 0;
        ink_row_lo = STORE_ROWS;
        ink_row_hi = 0;
    endtask

    task automatic send_row(input logic [63:0] bits, input logic [6:0] width,
                            input logic signed [10:0] left,
                            input logic signed [10:0] top, input logic fin);
        int gap;
        gap = (idle_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        row_bits   <= bits;
        row_width  <= width;
        glyph_left <= left;
        glyph_top  <= top;
        last_row   <= fin;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_row(bits, width, left, top, fin);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_cnt < 50)
            $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic check_beat();
        crop_beat_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch("beat with none pending", 64'(kind), '0);
            return;
        end
        want = expected_beats.pop_front();
        if (kind !== want.kind)
            report_mismatch("kind", 64'(kind), 64'(want.kind));
        if (box_width !== want.box_w)
            report_mismatch("box_width", 64'(box_width), 64'(want.box_w));
        if (box_height !== want.box_h)
            report_mismatch("box_height", 64'(box_height), 64'(want.box_h));
        if ($unsigned(box_x_offset) !== want.x_off)
            report_mismatch("box_x_offset", 64'($unsigned(box_x_offset)), 64'(want.x_off));
        if ($unsigned(box_y_offset) !== want.y_off)
            report_mismatch("box_y_offset", 64'($unsigned(box_y_offset)), 64'(want.y_off));
        if (cropped_row !== want.bits)
            report_mismatch("cropped_row", cropped_row, want.bits);
        if (font_box_width !== want.span)
            report_mismatch("font_box_width", 64'(font_box_width), 64'(want.span));
        if (font_max_ascent !== want.ascent)
            report_mismatch("font_max_ascent", 64'(font_max_ascent), 64'(want.ascent));
        if (font_max_descent !== want.descent)
            report_mismatch("font_max_descent", 64'(font_max_descent), 64'(want.descent));
        if ($unsigned(font_min_left) !== want.min_left)
            report_mismatch("font_min_left", 64'($unsigned(font_min_left)),
                            64'(want.min_left));
        if (all_same_width !== want.mono)
            report_mismatch("all_same_width", 64'(all_same_width), 64'(want.mono));
        if (last !== want.last)
            report_mismatch("last", 64'(last), 64'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            check_beat();
    end

    always @(posedge clk)
    begin
        if (stall_hold > 0)
            stall_hold--;
        else if (!out_stall && idle_on && $urandom_range(0, 2) == 0)
        begin
            out_stall  <= 1'b1;
            stall_hold = pick_gap();
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_hold = $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // two glyphs of equal box width keep the monowidth flag set
    task automatic test_equal_widths();
        send_row(64'hC000_0000_0000_0000, 7'd8, 11'sd0, 11'sd8, 1'b0);
        send_row(64'h6000_0000_0000_0000, 7'd8, 11'sd0, 11'sd8, 1'b1);
        send_row(64'h0E00_0000_0000_0000, 7'd16, 11'sd2, 11'sd5, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_row(ONES64, 7'd64, -11'sd1024, 11'sd1023, 1'b1);
        send_row(ONES64, 7'd127, 11'sd1023, -11'sd1024, 1'b1);
        send_row(ONES64, 7'd0, 11'sd5, 11'sd3, 1'b1);
        send_row(64'h0000_0000_0000_0001, 7'd64, 11'sd0, 11'sd0, 1'b1);
        send_row(64'h0, 7'd64, -11'sd7, 11'sd9, 1'b0);
        send_row(64'h0, 7'd64, 11'sd4, -11'sd2, 1'b1);
        send_row(64'h8000_0000_0000_0000, 7'd1, -11'sd3, 11'sd12, 1'b1);
    endtask

    // ink box inside a taller bitmap, ragged widths, junk offsets before the last row
    task automatic test_tall_glyph();
        send_row(64'h0, 7'd64, 11'sd300, -11'sd300, 1'b0);
        send_row(64'h0018_0000_0000_0000, 7'd64, -11'sd500, 11'sd77, 1'b0);
        send_row(64'h07E0_0000_0000_0000, 7'd40, 11'sd1, 11'sd1, 1'b0);
        send_row(ONES64, 7'd20, 11'sd0, 11'sd0, 1'b0);
        send_row(64'h0000_0000_0000_0003, 7'd70, 11'sd9, -11'sd9, 1'b0);
        send_row(64'h0, 7'd64, -11'sd2, 11'sd20, 1'b1);
    endtask

    // rows past the store depth are dropped, the last mark on one still closes the glyph
    task automatic test_overflow_rows();
        logic [63:0] bits;
        for (int r = 0; r < STORE_ROWS + 2; r++)
        begin
            bits = (r == 0 || r == STORE_ROWS - 1 || r >= STORE_ROWS) ? ONES64 : rand_row();
            send_row(bits, 7'd64, 11'sd10, 11'sd40, r == STORE_ROWS + 1);
        end
    endtask

    task automatic test_random_glyphs();
        int                 rows;
        int                 sent;
        logic [6:0]         w;
        logic signed [10:0] lx;
        logic signed [10:0] ty;
        bit                 fin;
        sent = 0;
        while (sent < 45)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            rows = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            w    = pick_width();
            lx   = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 40) - 20);
            ty   = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 40) - 8);
            for (int r = 0; r < rows; r++)
            begin
                fin = (r == rows - 1);
                if (!fin && $urandom_range(0, 3) == 0)
                    send_row(rand_row(), ($urandom_range(0, 4) == 0) ? pick_width() : w,
                             11'($urandom), 11'($urandom), 1'b0);
                else
                    send_row(rand_row(), ($urandom_range(0, 4) == 0) ? pick_width() : w,
                             lx, ty, fin);
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_equal_widths();
        test_field_extremes();
        test_tall_glyph();
        test_overflow_rows();
        test_random_glyphs();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== glyph_bitmap_crop.f =====
rtl/gbc_pkg.sv
rtl/gbc_ink_track.sv
rtl/gbc_row_store.sv
rtl/gbc_font_stats.sv
rtl/glyph_bitmap_crop.sv
tb/sv/glyph_bitmap_crop_test.sv
